>>> src/page_frame_bitmap_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
// Asserts that a condition implies a consequence on the same edge.
`define PFBA_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Asserts that a condition implies a consequence on the next edge.
`define PFBA_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

>>> src/pfba_pkg.sv
// Package with the shared types and constants of the page frame allocator.
package pfba_pkg;
   localparam int unsigned DefMaxPages      = 32768;
   localparam int unsigned DefReservedPages = 1024;
   localparam int unsigned CountW           = 16;
   localparam int unsigned AddrW            = 32;
   localparam int unsigned PageShift        = 12;
   localparam logic [7:0]  FullByte         = 8'hff;
   localparam logic        ActAlloc         = 1'b0;
   localparam logic        ActFree          = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BF_RD, ST_BF_CHK, ST_FF_RD, ST_FF_CHK,
      ST_MARK_RD, ST_MARK_WR, ST_FR_RD, ST_FR_WR, ST_DONE
   } state_type;

   // Best fit within one byte: shortest free run of at least cnt, lowest on tie.
   typedef struct packed {
      logic       found;
      logic [2:0] pos;
   } fit_type;

   function automatic fit_type best_in_byte(input logic [7:0] b, input logic [3:0] cnt);
      fit_type    r;
      logic [3:0] best_len;
      logic [3:0] run;
      logic [2:0] start;
      r = '0;
      best_len = 4'd9;
      run = '0;
      start = '0;
      for (int j = 0; j < 8; j++) begin
         if (!b[j]) begin
            if (run == 4'd0) start = 3'(j);
            run = run + 4'd1;
         end
         if (b[j] || j == 7) begin
            if (run >= cnt && run < best_len) begin
               best_len = run;
               r.pos = start;
               r.found = 1'b1;
            end
            run = '0;
         end
      end
      return r;
   endfunction
endpackage

>>> src/page_frame_bitmap_allocator_top.sv
// Top level of the page frame bitmap allocator.
// The block keeps one bit per 4 KiB page in a byte-wide synchronous memory of
// MAX_PAGES/8 entries and works on one item at a time; busy is high from the
// accepted start until the result strobe. After reset a clearing pass writes
// every byte, one a cycle, during which busy stays high. An allocate of 1 to 8
// pages scans the bytes until a fit, reading each in ST_BF_RD and checking it
// in ST_BF_CHK, and then marks its run page by page, reading in ST_MARK_RD and
// writing in ST_MARK_WR. A larger allocate walks the pages one at a time
// through ST_FF_RD and ST_FF_CHK, since the byte is read again for every page,
// and then marks its run the same way. A free reads and then updates each page
// below the total in ST_FR_RD and ST_FR_WR and only flags each page at or
// beyond it in ST_FR_RD. Every item ends in ST_DONE, which carries the result.
// The result strobe rsp_valid is high for exactly one cycle and the receiver
// cannot stall it, so the result must be captured in that cycle.
module page_frame_bitmap_allocator_top #(
   parameter int unsigned MAX_PAGES      = pfba_pkg::DefMaxPages,
   parameter int unsigned RESERVED_PAGES = pfba_pkg::DefReservedPages
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [pfba_pkg::CountW-1:0] req_page_count,
   input  logic [pfba_pkg::AddrW-1:0]  req_free_address,
   output logic                        rsp_valid,
   output logic                        rsp_success,
   output logic [pfba_pkg::AddrW-1:0]  rsp_alloc_address,
   output logic                        rsp_double_free,
   output logic                        rsp_out_of_range,
   input  logic                        csr_we,
   input  logic [pfba_pkg::CountW-1:0] csr_wdata
);
   import pfba_pkg::*;
`include "page_frame_bitmap_allocator_top_defines.svh"

   localparam int unsigned Bytes = MAX_PAGES / 8;
   localparam int unsigned BW    = $clog2(Bytes);
   localparam int unsigned PW    = BW + 3;
   localparam int unsigned TW    = PW + 1;

   logic [7:0] mem [Bytes];
   logic [7:0] rd_data_ff;
   logic       we;
   logic [BW-1:0] waddr, raddr;
   logic [7:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [CountW-1:0] total_ff;
   logic [TW-1:0]     eff_total;
   logic [BW:0]       byte_ff, byte_in;        // scan byte index
   logic [PW:0]       page_ff, page_in;        // current page (may run past)
   logic [PW:0]       run_start_ff, run_start_in;
   logic [CountW:0]   run_ff, run_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [CountW-1:0] left_ff, left_in;
   logic              act_ff, act_in;
   logic              succ_ff, succ_in, dbl_ff, dbl_in, oor_ff, oor_in;
   logic [PW:0]       res_ff, res_in;
   logic [AddrW-PageShift-1:0] fpage_ff, fpage_in;
   logic              fp_hi_ff, fp_hi_in;      // free page beyond index width

   always_comb begin
      if ({16'd0, total_ff} < 32'(MAX_PAGES)) eff_total = TW'(total_ff);
      else eff_total = TW'(MAX_PAGES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         total_ff <= 16'd32768;
         byte_ff  <= '0;
      end else begin
         state_ff <= state_in;
         byte_ff  <= byte_in;
         if (csr_we) total_ff <= csr_wdata;
      end
      page_ff <= page_in; run_start_ff <= run_start_in; run_ff <= run_in;
      cnt_ff <= cnt_in; left_ff <= left_in; act_ff <= act_in;
      succ_ff <= succ_in; dbl_ff <= dbl_in; oor_ff <= oor_in; res_ff <= res_in;
      fpage_ff <= fpage_in; fp_hi_ff <= fp_hi_in;
   end

   fit_type fit;
   logic [7:0] cur_bit_mask;
   logic       cur_used;
   logic [BW:0] res_bytes;

   always_comb begin
      fit = best_in_byte(rd_data_ff, cnt_ff[3:0]);
      cur_bit_mask = 8'(1) << page_ff[2:0];
      cur_used = |(rd_data_ff & cur_bit_mask);
      res_bytes = (BW+1)'((RESERVED_PAGES < MAX_PAGES ? RESERVED_PAGES : MAX_PAGES) / 8);
   end

   always_comb begin
      state_in = state_ff; byte_in = byte_ff; page_in = page_ff;
      run_start_in = run_start_ff; run_in = run_ff; cnt_in = cnt_ff;
      left_in = left_ff; act_in = act_ff; succ_in = succ_ff; dbl_in = dbl_ff;
      oor_in = oor_ff; res_in = res_ff; fpage_in = fpage_ff; fp_hi_in = fp_hi_ff;
      we = 1'b0; waddr = byte_ff[BW-1:0]; wdata = '0; raddr = byte_ff[BW-1:0];
      busy = 1'b1; rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // Reserved bytes full; a trailing partial reserved byte gets low bits.
            we = 1'b1;
            if (byte_ff < res_bytes) wdata = FullByte;
            else if (byte_ff == res_bytes)
               wdata = 8'((9'd1 << (RESERVED_PAGES % 8)) - 9'd1);
            else wdata = '0;
            if (32'(byte_ff) == 32'(Bytes - 1)) begin
               byte_in = '0; state_in = ST_IDLE;
            end else byte_in = byte_ff + 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               act_in = req_action; cnt_in = req_page_count; left_in = req_page_count;
               succ_in = 1'b0; dbl_in = 1'b0; oor_in = 1'b0; res_in = '0;
               byte_in = '0; page_in = '0; run_in = '0; run_start_in = '0;
               fpage_in = req_free_address[AddrW-1:PageShift];
               if (req_page_count == '0) state_in = ST_DONE;
               else if (req_action == ActFree) begin
                  page_in  = (PW+1)'(req_free_address[AddrW-1:PageShift]);
                  fp_hi_in = 1'b0;
                  state_in = ST_FR_RD;
               end else if (req_page_count > 16'd8) state_in = ST_FF_RD;
               else state_in = ST_BF_RD;
            end
         end
         ST_BF_RD: begin
            if ({byte_ff, 3'b000} + 3'd0 >= (BW+4)'(eff_total) - (BW+4)'(eff_total[2:0])
                || {byte_ff, 3'b000} >= (BW+4)'(eff_total))
               state_in = ST_DONE;
            else begin
               raddr = byte_ff[BW-1:0]; state_in = ST_BF_CHK;
            end
         end
         ST_BF_CHK: begin
            if (rd_data_ff != FullByte && fit.found) begin
               page_in = {1'b0, byte_ff[BW-1:0], fit.pos}; res_in = page_in;
               left_in = cnt_ff; succ_in = 1'b1; state_in = ST_MARK_RD;
            end else begin
               byte_in = byte_ff + 1'b1; state_in = ST_BF_RD;
            end
         end
         ST_FF_RD: begin
            if ((TW)'(page_ff) >= eff_total) state_in = ST_DONE;
            else begin
               raddr = page_ff[PW-1:3]; state_in = ST_FF_CHK;
            end
         end
         ST_FF_CHK: begin
            // One page per visit; the byte is re-read for simplicity per page.
            if (!cur_used) begin
               if (run_ff == '0) run_start_in = page_ff;
               run_in = run_ff + 1'b1;
               if (run_ff + 1'b1 == {1'b0, cnt_ff}) begin
                  res_in = (run_ff == '0) ? page_ff : run_start_ff;
                  page_in = res_in; left_in = cnt_ff; succ_in = 1'b1;
                  state_in = ST_MARK_RD;
               end else begin
                  page_in = page_ff + 1'b1; state_in = ST_FF_RD;
               end
            end else begin
               run_in = '0; page_in = page_ff + 1'b1; state_in = ST_FF_RD;
            end
         end
         ST_MARK_RD: begin
            if (left_ff == '0) state_in = ST_DONE;
            else begin
               raddr = page_ff[PW-1:3]; state_in = ST_MARK_WR;
            end
         end
         ST_MARK_WR: begin
            we = 1'b1; waddr = page_ff[PW-1:3]; wdata = rd_data_ff | cur_bit_mask;
            page_in = page_ff + 1'b1; left_in = left_ff - 1'b1; state_in = ST_MARK_RD;
         end
         ST_FR_RD: begin
            if (left_ff == '0) begin
               succ_in = !dbl_ff && !oor_ff; state_in = ST_DONE;
            end else if (fp_hi_ff || fpage_ff >= (AddrW-PageShift)'(eff_total)) begin
               oor_in = 1'b1; left_in = left_ff - 1'b1;
               {fp_hi_in, fpage_in} = {1'b0, fpage_ff} + 1'b1 | {fp_hi_ff, 20'd0};
            end else begin
               page_in = (PW+1)'(fpage_ff);
               raddr = fpage_ff[PW-1:3]; state_in = ST_FR_WR;
            end
         end
         ST_FR_WR: begin
            if (cur_used) begin
               we = 1'b1; waddr = page_ff[PW-1:3]; wdata = rd_data_ff & ~cur_bit_mask;
            end else dbl_in = 1'b1;
            left_in = left_ff - 1'b1;
            {fp_hi_in, fpage_in} = {1'b0, fpage_ff} + 1'b1;
            state_in = ST_FR_RD;
         end
         ST_DONE: begin
            rsp_valid = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_success       = succ_ff;
   assign rsp_alloc_address = (act_ff == ActAlloc && succ_ff) ?
                              AddrW'({res_ff, 12'd0}) : '0;
   assign rsp_double_free   = dbl_ff;
   assign rsp_out_of_range  = oor_ff;

   `PFBA_ASSERT_IMP(a_valid_busy, clock, reset, rsp_valid, busy, "result while not busy")
   `PFBA_ASSERT_NEXT(a_valid_one, clock, reset, rsp_valid, !rsp_valid, "strobe held")
   `PFBA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   `PFBA_ASSERT_IMP(a_alloc_flags, clock, reset, rsp_valid && act_ff == ActAlloc,
                    !rsp_double_free && !rsp_out_of_range, "alloc with free flags")
endmodule

>>> tb/tb.sv
// Self-checking testbench for the page frame bitmap allocator.
`timescale 1ns / 1ps

module tb;
   import pfba_pkg::*;

   localparam int unsigned MaxPages  = DefMaxPages;
   localparam int unsigned Reserved  = DefReservedPages;
   localparam int unsigned PageBytes = 4096;

   // One result as the block reports it.
   typedef struct packed {
      logic             success;
      logic [AddrW-1:0] alloc_address;
      logic             double_free;
      logic             out_of_range;
   } alloc_rsp_type;

   // One row of the directed table. When has_exp is set the typed result is
   // checked instead of the predicted one; the prediction still updates state.
   typedef struct packed {
      logic              action;
      logic [CountW-1:0] count;
      logic [AddrW-1:0]  address;
      logic              has_exp;
      alloc_rsp_type     exp;
   } directed_row_type;

   // A run that an allocate of up to 64 pages handed out, kept so that it can be freed.
   typedef struct packed {
      logic [AddrW-1:0]  address;
      logic [CountW-1:0] count;
   } live_run_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_action;
   logic [CountW-1:0] req_page_count;
   logic [AddrW-1:0]  req_free_address;
   logic              rsp_valid;
   logic              rsp_success;
   logic [AddrW-1:0]  rsp_alloc_address;
   logic              rsp_double_free;
   logic              rsp_out_of_range;
   logic              csr_we;
   logic [CountW-1:0] csr_wdata;

   // Shadow copy of the page bitmap and of the total pages register.
   bit [MaxPages-1:0] page_map;
   int unsigned       total_reg;

   alloc_rsp_type    pending_rsp[$];
   live_run_type     live_runs[$];
   directed_row_type directed_rows[$];
   int               error_count;
   int               idle_pct;

   page_frame_bitmap_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_page_count   (req_page_count),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_success      (rsp_success),
      .rsp_alloc_address(rsp_alloc_address),
      .rsp_double_free  (rsp_double_free),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   // The clock runs at a 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // The run is cut off after a generous fixed time in case the block hangs.
   initial begin
      #400000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned managed_pages();
      return (total_reg < MaxPages) ? total_reg : MaxPages;
   endfunction

   // Works out the result of one item and applies it to the shadow bitmap.
   // Small requests take the shortest fitting run in the first byte that has
   // one; larger requests take the first long enough run over all pages.
   function automatic alloc_rsp_type predict_allocation(logic act, logic [CountW-1:0] cnt,
                                                        logic [AddrW-1:0] addr);
      alloc_rsp_type r;
      int unsigned tot;
      int unsigned page;
      int unsigned run;
      int unsigned run_start;
      int unsigned best_len;
      int unsigned best_pos;
      bit          found;
      bit [7:0]    b;
      r = '0;
      tot = managed_pages();
      found = 1'b0;
      page = 0;
      if (cnt == 0) return r;
      if (act == ActAlloc) begin
         if (cnt > 8) begin
            run = 0;
            run_start = 0;
            for (int unsigned p = 0; p < tot && !found; p++) begin
               if (!page_map[p]) begin
                  if (run == 0) run_start = p;
                  run++;
                  if (run == cnt) begin
                     found = 1'b1;
                     page = run_start;
                  end
               end else begin
                  run = 0;
               end
            end
         end else begin
            for (int unsigned i = 0; i < tot / 8 && !found; i++) begin
               b = page_map[i*8 +: 8];
               if (b != FullByte) begin
                  best_len = 9;
                  best_pos = 0;
                  run = 0;
                  run_start = 0;
                  for (int unsigned j = 0; j < 8; j++) begin
                     if (!b[j]) begin
                        if (run == 0) run_start = j;
                        run++;
                     end
                     if (b[j] || j == 7) begin
                        if (run >= cnt && run < best_len) begin
                           best_len = run;
                           best_pos = run_start;
                           found = 1'b1;
                        end
                        run = 0;
                     end
                  end
                  if (found) page = i * 8 + best_pos;
               end
            end
         end
         if (found) begin
            for (int unsigned k = 0; k < cnt; k++) page_map[page + k] = 1'b1;
            r.success = 1'b1;
            r.alloc_address = AddrW'(page * PageBytes);
         end
      end else begin
         for (int unsigned k = 0; k < cnt; k++) begin
            page = (addr >> PageShift) + k;
            if (page >= tot) r.out_of_range = 1'b1;
            else if (page_map[page]) page_map[page] = 1'b0;
            else r.double_free = 1'b1;
         end
         r.success = !r.double_free && !r.out_of_range;
      end
      return r;
   endfunction

   // Offers one item and holds it until the block takes it. Start is left
   // high so that a back-to-back item does not drop it in between.
   task automatic send_item(logic act, logic [CountW-1:0] cnt, logic [AddrW-1:0] addr,
                            logic has_exp, alloc_rsp_type exp);
      alloc_rsp_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= act;
      req_page_count   <= cnt;
      req_free_address <= addr;
      do @(posedge clock); while (busy);
      r = predict_allocation(act, cnt, addr);
      if (has_exp) r = exp;
      pending_rsp.push_back(r);
      if (act == ActAlloc && r.success && cnt <= 64)
         live_runs.push_back('{address: r.alloc_address, count: cnt});
   endtask

   // Lets every outstanding result come back with start held low.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
   endtask

   // Writes total pages while the block is idle.
   task automatic write_total(logic [CountW-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      total_reg = value;
   endtask

   // Random items: mostly small allocations and frees of runs handed out
   // earlier, with some large requests, zero counts and stray frees mixed in.
   task automatic random_phase(int n_items, int pct);
      int           kind;
      int           idx;
      live_run_type lr;
      idle_pct = pct;
      for (int n = 0; n < n_items; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_item(ActAlloc, CountW'($urandom_range(1, 8)), $urandom, 1'b0, '0);
         end else if (kind < 55) begin
            send_item(ActAlloc, CountW'($urandom_range(9, 40)), $urandom, 1'b0, '0);
         end else if (kind < 80 && live_runs.size() != 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            lr = live_runs[idx];
            live_runs.delete(idx);
            send_item(ActFree, lr.count,
                      lr.address | AddrW'($urandom_range(0, PageBytes - 1)), 1'b0, '0);
         end else if (kind < 90) begin
            send_item(ActFree, CountW'($urandom_range(1, 12)),
                      AddrW'($urandom_range(0, 2 * managed_pages())) << PageShift,
                      1'b0, '0);
         end else if (kind < 95) begin
            send_item(ActFree, CountW'($urandom_range(0, 4)), $urandom, 1'b0, '0);
         end else begin
            send_item(1'($urandom_range(0, 1)), '0, $urandom, 1'b0, '0);
         end
         // Now and then the sender waits for everything to come back.
         if ($urandom_range(0, 19) == 0) drain();
      end
   endtask

   // Results are compared with the oldest expectation in the edge that ends
   // the strobe cycle.
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_success !== e.success) begin
               $error("success: expected %0d, got %0d", e.success, rsp_success);
               error_count++;
            end
            if (rsp_alloc_address !== e.alloc_address) begin
               $error("alloc_address: expected %08h, got %08h", e.alloc_address,
                      rsp_alloc_address);
               error_count++;
            end
            if (rsp_double_free !== e.double_free) begin
               $error("double_free: expected %0d, got %0d", e.double_free, rsp_double_free);
               error_count++;
            end
            if (rsp_out_of_range !== e.out_of_range) begin
               $error("out_of_range: expected %0d, got %0d", e.out_of_range,
                      rsp_out_of_range);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count = 0;
      idle_pct    = 0;
      total_reg   = 32768;
      page_map    = '0;
      for (int unsigned p = 0; p < Reserved; p++) page_map[p] = 1'b1;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ActAlloc;
      req_page_count   <= '0;
      req_free_address <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;

      // Directed table. Reserved pages end at page 1024, so the first single
      // page goes to address 0x0040_0000. The full-range free clears the map,
      // hitting both already free pages and pages past the total.
      directed_rows = '{
         '{ActAlloc, 16'd1,     32'h0,          1'b1, '{1'b1, 32'h0040_0000, 1'b0, 1'b0}},
         '{ActAlloc, 16'd0,     32'hFFFF_FFFF,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b0}},
         '{ActFree,  16'd0,     32'h0,          1'b1, '{1'b0, 32'h0, 1'b0, 1'b0}},
         '{ActAlloc, 16'd8,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'd3,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'd2,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'd9,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'd300,   32'h0,          1'b0, '0},
         '{ActFree,  16'd1,     32'h0040_0000,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0}},
         '{ActFree,  16'd1,     32'h0040_0000,  1'b1, '{1'b0, 32'h0, 1'b1, 1'b0}},
         '{ActFree,  16'd1,     32'hFFFF_F000,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1}},
         '{ActFree,  16'd2,     32'h0040_0FFF,  1'b0, '0},
         '{ActAlloc, 16'd1,     32'h0,          1'b0, '0},
         '{ActFree,  16'd4,     32'h0040_2000,  1'b0, '0},
         '{ActAlloc, 16'hFFFF,  32'h0,          1'b1, '{1'b0, 32'h0, 1'b0, 1'b0}},
         '{ActFree,  16'hFFFF,  32'h0,          1'b1, '{1'b0, 32'h0, 1'b1, 1'b1}},
         '{ActAlloc, 16'd8,     32'h0,          1'b1, '{1'b1, 32'h0, 1'b0, 1'b0}},
         '{ActAlloc, 16'd1,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'd5,     32'h0,          1'b0, '0},
         '{ActAlloc, 16'h8000,  32'h0,          1'b1, '{1'b0, 32'h0, 1'b0, 1'b0}},
         '{ActFree,  16'd3,     32'h0000_1000,  1'b0, '0},
         '{ActAlloc, 16'd2,     32'h0,          1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A value above the maximum is clamped by the block to the full store.
      write_total(16'hFFFF);
      foreach (directed_rows[i])
         send_item(directed_rows[i].action, directed_rows[i].count,
                   directed_rows[i].address, directed_rows[i].has_exp,
                   directed_rows[i].exp);

      // A total with a partial trailing byte, reachable only by first fit.
      write_total(16'd1100);
      random_phase(30, 0);
      // The smallest total leaves a single byte.
      write_total(16'd8);
      random_phase(15, 78);
      write_total(16'd2048);
      random_phase(30, 0);
      write_total(16'h8000);
      random_phase(30, 25);
      write_total(16'd1031);
      random_phase(13, 78);

      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
